[hw/rtl/itcf_pkg.sv]
package itcf_pkg;

  // Fixed sizes of the arithmetic, chosen for the widest parameter setting
  localparam int SQRT_STEPS = 24;  // result bits of the radius square root
  localparam int ATAN_LEN   = 24;  // entries of the arctangent table
  localparam int DIV_DIGITS = 4;   // 16-bit digits of a dividend
  localparam int DIV_NW     = 16 * DIV_DIGITS;  // dividend and quotient width
  localparam int DIV_DW     = 10;  // divisor width, constants up to 1000
  localparam int RCP_W      = 30;  // reciprocal width
  localparam int RCP_SHIFT  = 36;  // reciprocal scale, 2^36

  // Axis index codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_B,
    OP_SQ_C,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_CORDIC_INIT,
    OP_CORDIC_STEP,
    OP_SPECIAL,
    OP_DEG_GO,
    OP_DEG_WAIT,
    OP_RATE_GO,
    OP_RATE_WAIT,
    OP_GTERM_GO,
    OP_GTERM_WAIT,
    OP_SUM,
    OP_BLEND_GO,
    OP_BLEND_WAIT,
    OP_NEXT_AXIS,
    OP_COMMIT
  } dp_op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_B,
    ST_SQ_C,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_SPECIAL,
    ST_DEG_GO,
    ST_DEG_WAIT,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_GTERM_GO,
    ST_GTERM_WAIT,
    ST_SUM,
    ST_BLEND_GO,
    ST_BLEND_WAIT,
    ST_NEXT,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_last;
    logic cordic_last;
    logic rad_zero;
    logic last_axis;
  } sts_t;

  // atan(2^-i) in radians, Q32
  function automatic logic [33:0] atan_q32(input logic [4:0] idx);
    logic [33:0] v;
    case (idx)
      5'd0:    v = 34'd3373259426;
      5'd1:    v = 34'd1991351318;
      5'd2:    v = 34'd1052175346;
      5'd3:    v = 34'd534100635;
      5'd4:    v = 34'd268086748;
      5'd5:    v = 34'd134174063;
      5'd6:    v = 34'd67103403;
      5'd7:    v = 34'd33553749;
      5'd8:    v = 34'd16777131;
      5'd9:    v = 34'd8388597;
      5'd10:   v = 34'd4194303;
      5'd11:   v = 34'd2097152;
      5'd12:   v = 34'd1048576;
      5'd13:   v = 34'd524288;
      5'd14:   v = 34'd262144;
      5'd15:   v = 34'd131072;
      5'd16:   v = 34'd65536;
      5'd17:   v = 34'd32768;
      5'd18:   v = 34'd16384;
      5'd19:   v = 34'd8192;
      5'd20:   v = 34'd4096;
      5'd21:   v = 34'd2048;
      5'd22:   v = 34'd1024;
      5'd23:   v = 34'd512;
      default: v = 34'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/itcf_div.sv]
module itcf_div
  import itcf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  input  logic [RCP_W-1:0]  rcp_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  localparam int CNTW = $clog2(DIV_DIGITS + 1);
  localparam int TW   = DIV_DW + 16;
  localparam int PW   = TW + RCP_W;

  logic [DIV_NW-1:0] n_q, n_d;
  logic [DIV_DW-1:0] r_q, r_d;
  logic [TW-1:0]     t_q, t_d;
  logic [15:0]       qd_q, qd_d;
  logic [DIV_DW-1:0] d_q;
  logic [RCP_W-1:0]  rcp_q;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              ph_q, ph_d;
  logic              done_q, done_d;
  logic [TW-1:0]     t_w, rem_w;
  logic [PW-1:0]     prod_w;

  // one digit: partial remainder takes the next 16 dividend bits,
  // quotient digit by reciprocal multiply, remainder by multiply-subtract
  assign t_w    = {r_q, n_q[DIV_NW-1 -: 16]};
  assign prod_w = PW'(t_w) * PW'(rcp_q);
  assign rem_w  = t_q - TW'(qd_q) * TW'(d_q);

  always_comb begin
    n_d    = n_q;
    r_d    = r_q;
    t_d    = t_q;
    qd_d   = qd_q;
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d   = num_i;
      r_d   = '0;
      cnt_d = CNTW'(DIV_DIGITS);
      ph_d  = 1'b0;
    end else if (cnt_q != '0) begin
      if (!ph_q) begin
        t_d  = t_w;
        qd_d = prod_w[RCP_SHIFT +: 16];
        ph_d = 1'b1;
      end else begin
        n_d    = {n_q[DIV_NW-17:0], qd_q};
        r_d    = rem_w[DIV_DW-1:0];
        ph_d   = 1'b0;
        cnt_d  = cnt_q - CNTW'(1);
        done_d = (cnt_q == CNTW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ph_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    r_q  <= r_d;
    t_q  <= t_d;
    qd_q <= qd_d;
    if (start_i) begin
      d_q   <= den_i;
      rcp_q <= rcp_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

  // a new division never starts over one in progress
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("divider started while busy");

endmodule

[hw/rtl/itcf_dp.sv]
module itcf_dp
  import itcf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  logic [111:0] in_data_i,
  output logic [95:0]  out_data_o
);

  localparam int CW     = $clog2(CORDIC_STEPS);
  localparam int DEG_SH = 32 - ANGLE_FRAC_BITS;
  localparam logic [DIV_NW-1:0] DEG_HALF = DIV_NW'(157) << (DEG_SH - 1);
  localparam logic [DIV_DW-1:0] DEG_DEN  = DIV_DW'(157);
  localparam logic [DIV_DW-1:0] RATE_DEN = DIV_DW'(131);
  localparam logic [DIV_DW-1:0] GT_DEN   = DIV_DW'(1000);
  localparam logic [DIV_DW-1:0] BL_DEN   = DIV_DW'(100);
  // reciprocals ceil(2^36 / d)
  localparam logic [RCP_W-1:0]  DEG_RCP  =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd156) / 64'd157);
  localparam logic [RCP_W-1:0]  RATE_RCP =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd130) / 64'd131);
  localparam logic [RCP_W-1:0]  GT_RCP   =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd999) / 64'd1000);
  localparam logic [RCP_W-1:0]  BL_RCP   =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'd99) / 64'd100);
  localparam logic signed [32:0] NINETY  = 33'(90) << ANGLE_FRAC_BITS;
  localparam logic [DIV_NW-1:0] SAT_POS  = DIV_NW'(32'h7fff_ffff);
  localparam logic [DIV_NW-1:0] SAT_NEG  = DIV_NW'(32'h8000_0000);

  // sample registers
  logic signed [15:0] acc_in_q [3];
  logic signed [15:0] gyr_in_q [3];
  logic        [15:0] ms_q;
  logic        [1:0]  axis_q;

  // per-axis working registers
  logic        [31:0] sum_q;
  logic        [47:0] rad_q;
  logic        [27:0] rem_q;
  logic        [23:0] root_q;
  logic        [4:0]  sq_cnt_q;
  logic signed [26:0] cx_q, cy_q;
  logic signed [33:0] cz_q;
  logic        [CW-1:0] ci_q;
  logic               sign_q;
  logic signed [32:0] acc_q;
  logic        [7:0]  rate_q;
  logic signed [39:0] gterm_q;
  logic signed [47:0] v_q;
  logic signed [31:0] res_q   [3];
  logic signed [31:0] prior_q [3];

  // axis operand selection
  logic signed [15:0] a_w, b_w, c_w, g_w;
  logic signed [31:0] prior_w;

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        a_w = acc_in_q[0]; b_w = acc_in_q[1]; c_w = acc_in_q[2];
        g_w = gyr_in_q[0]; prior_w = prior_q[0];
      end
      AXIS_Y: begin
        a_w = acc_in_q[1]; b_w = acc_in_q[0]; c_w = acc_in_q[2];
        g_w = gyr_in_q[1]; prior_w = prior_q[1];
      end
      default: begin
        a_w = acc_in_q[2]; b_w = acc_in_q[0]; c_w = acc_in_q[1];
        g_w = gyr_in_q[2]; prior_w = prior_q[2];
      end
    endcase
  end

  // squares of the two other axes
  logic signed [31:0] sq_b_w, sq_c_w;
  assign sq_b_w = b_w * b_w;
  assign sq_c_w = c_w * c_w;

  // square root step, two radicand bits per step
  logic [27:0] remx_w, trial_w;
  logic        sq_ge_w;
  assign remx_w  = {rem_q[25:0], rad_q[47:46]};
  assign trial_w = {2'b00, root_q, 2'b01};
  assign sq_ge_w = remx_w >= trial_w;

  // CORDIC vectoring step
  logic signed [26:0] xs_w, ys_w;
  logic signed [33:0] at_w;
  assign xs_w = cx_q >>> ci_q;
  assign ys_w = cy_q >>> ci_q;
  assign at_w = $signed(atan_q32(5'(ci_q)));

  // divider operands
  logic [33:0] zmag_w;
  logic [47:0] deg_prod_w;
  logic [16:0] gmag_w;
  logic [23:0] gprod_w;
  logic [46:0] vmag_w;
  logic signed [40:0] s_w;
  logic signed [47:0] v_w;
  assign zmag_w     = cz_q[33] ? 34'(-cz_q) : 34'(cz_q);
  assign deg_prod_w = zmag_w * 48'd9000;
  assign gmag_w     = g_w[15] ? 17'(-17'(g_w)) : 17'(g_w);
  assign gprod_w    = rate_q * ms_q;
  assign vmag_w     = v_q[47] ? 47'(-v_q) : 47'(v_q);
  assign s_w        = 41'(prior_w) + 41'(gterm_q);
  assign v_w        = 48'(s_w) * 48'sd98 + (48'(acc_q) <<< 1);

  logic              div_start_w, div_done_w;
  logic [DIV_NW-1:0] div_n_w, div_q_w;
  logic [DIV_DW-1:0] div_d_w;
  logic [RCP_W-1:0]  div_r_w;

  // the degree divisor 157 * 2^(32-F) splits into a shift and a division by 157
  always_comb begin
    div_start_w = 1'b0;
    div_n_w     = '0;
    div_d_w     = '0;
    div_r_w     = '0;
    case (cmd_i.op)
      OP_DEG_GO: begin
        div_start_w = 1'b1;
        div_n_w     = (DIV_NW'(deg_prod_w) + DEG_HALF) >> DEG_SH;
        div_d_w     = DEG_DEN;
        div_r_w     = DEG_RCP;
      end
      OP_RATE_GO: begin
        div_start_w = 1'b1;
        div_n_w     = DIV_NW'(gmag_w);
        div_d_w     = RATE_DEN;
        div_r_w     = RATE_RCP;
      end
      OP_GTERM_GO: begin
        div_start_w = 1'b1;
        div_n_w     = (DIV_NW'(gprod_w) << ANGLE_FRAC_BITS) + DIV_NW'(500);
        div_d_w     = GT_DEN;
        div_r_w     = GT_RCP;
      end
      OP_BLEND_GO: begin
        div_start_w = 1'b1;
        div_n_w     = DIV_NW'(vmag_w) + DIV_NW'(50);
        div_d_w     = BL_DEN;
        div_r_w     = BL_RCP;
      end
      default: ;
    endcase
  end

  itcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_w),
    .num_i  (div_n_w),
    .den_i  (div_d_w),
    .rcp_i  (div_r_w),
    .done_o (div_done_w),
    .quot_o (div_q_w)
  );

  // saturated blend result
  logic signed [31:0] sat_w;
  always_comb begin
    if (sign_q) begin
      sat_w = (div_q_w > SAT_NEG) ? 32'sh8000_0000 : 32'(-div_q_w);
    end else begin
      sat_w = (div_q_w > SAT_POS) ? 32'sh7fff_ffff : 32'(div_q_w);
    end
  end

  // control registers: axis counter and stored angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q     <= AXIS_X;
      prior_q[0] <= '0;
      prior_q[1] <= '0;
      prior_q[2] <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD:      axis_q <= AXIS_X;
        OP_NEXT_AXIS: axis_q <= axis_q + 2'd1;
        OP_COMMIT: begin
          prior_q[0] <= res_q[0];
          prior_q[1] <= res_q[1];
          prior_q[2] <= res_q[2];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        acc_in_q[0] <= in_data_i[15:0];
        acc_in_q[1] <= in_data_i[31:16];
        acc_in_q[2] <= in_data_i[47:32];
        gyr_in_q[0] <= in_data_i[63:48];
        gyr_in_q[1] <= in_data_i[79:64];
        gyr_in_q[2] <= in_data_i[95:80];
        ms_q        <= in_data_i[111:96];
      end
      OP_SQ_B: sum_q <= $unsigned(sq_b_w);
      OP_SQ_C: sum_q <= sum_q + $unsigned(sq_c_w);
      OP_SQRT_INIT: begin
        rad_q    <= {sum_q, 16'h0000};
        rem_q    <= '0;
        root_q   <= '0;
        sq_cnt_q <= '0;
      end
      OP_SQRT_STEP: begin
        rem_q    <= sq_ge_w ? remx_w - trial_w : remx_w;
        root_q   <= {root_q[22:0], sq_ge_w};
        rad_q    <= {rad_q[45:0], 2'b00};
        sq_cnt_q <= sq_cnt_q + 5'd1;
      end
      OP_CORDIC_INIT: begin
        cx_q <= $signed({3'b000, root_q});
        cy_q <= $signed({{3{a_w[15]}}, a_w, 8'h00});
        cz_q <= '0;
        ci_q <= '0;
      end
      OP_CORDIC_STEP: begin
        if (!cy_q[26]) begin
          cx_q <= cx_q + ys_w;
          cy_q <= cy_q - xs_w;
          cz_q <= cz_q + at_w;
        end else begin
          cx_q <= cx_q - ys_w;
          cy_q <= cy_q + xs_w;
          cz_q <= cz_q - at_w;
        end
        ci_q <= ci_q + CW'(1);
      end
      OP_SPECIAL: begin
        if (a_w > 16'sd0)      acc_q <= NINETY;
        else if (a_w < 16'sd0) acc_q <= -NINETY;
        else                   acc_q <= '0;
      end
      OP_DEG_GO:   sign_q <= cz_q[33];
      OP_DEG_WAIT: if (div_done_w) acc_q <= sign_q ? -33'(div_q_w) : 33'(div_q_w);
      OP_RATE_GO:  sign_q <= g_w[15];
      OP_RATE_WAIT: if (div_done_w) rate_q <= div_q_w[7:0];
      OP_GTERM_WAIT: begin
        if (div_done_w) gterm_q <= sign_q ? -40'(div_q_w) : 40'(div_q_w);
      end
      OP_SUM:      v_q <= v_w;
      OP_BLEND_GO: sign_q <= v_q[47];
      OP_BLEND_WAIT: if (div_done_w) res_q[axis_q] <= sat_w;
      default: ;
    endcase
  end

  assign sts_o.div_done    = div_done_w;
  assign sts_o.sqrt_last   = (sq_cnt_q == 5'(SQRT_STEPS - 1));
  assign sts_o.cordic_last = (ci_q == CW'(CORDIC_STEPS - 1));
  assign sts_o.rad_zero    = (root_q == '0);
  assign sts_o.last_axis   = (axis_q == AXIS_Z);

  assign out_data_o = {prior_q[2], prior_q[1], prior_q[0]};

endmodule

[hw/rtl/itcf_ctrl.sv]
module itcf_ctrl
  import itcf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        commit_w;

  assign commit_w = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:        if (in_valid_i) state_d = ST_SQ_B;
      ST_SQ_B:        state_d = ST_SQ_C;
      ST_SQ_C:        state_d = ST_SQRT_INIT;
      ST_SQRT_INIT:   state_d = ST_SQRT;
      ST_SQRT:        if (sts_i.sqrt_last) state_d = ST_CORDIC_INIT;
      ST_CORDIC_INIT: state_d = sts_i.rad_zero ? ST_SPECIAL : ST_CORDIC;
      ST_CORDIC:      if (sts_i.cordic_last) state_d = ST_DEG_GO;
      ST_SPECIAL:     state_d = ST_RATE_GO;
      ST_DEG_GO:      state_d = ST_DEG_WAIT;
      ST_DEG_WAIT:    if (sts_i.div_done) state_d = ST_RATE_GO;
      ST_RATE_GO:     state_d = ST_RATE_WAIT;
      ST_RATE_WAIT:   if (sts_i.div_done) state_d = ST_GTERM_GO;
      ST_GTERM_GO:    state_d = ST_GTERM_WAIT;
      ST_GTERM_WAIT:  if (sts_i.div_done) state_d = ST_SUM;
      ST_SUM:         state_d = ST_BLEND_GO;
      ST_BLEND_GO:    state_d = ST_BLEND_WAIT;
      ST_BLEND_WAIT:  if (sts_i.div_done) state_d = ST_NEXT;
      ST_NEXT:        state_d = sts_i.last_axis ? ST_COMMIT : ST_SQ_B;
      ST_COMMIT:      if (commit_w) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      ST_IDLE:        if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_SQ_B:        cmd_o.op = OP_SQ_B;
      ST_SQ_C:        cmd_o.op = OP_SQ_C;
      ST_SQRT_INIT:   cmd_o.op = OP_SQRT_INIT;
      ST_SQRT:        cmd_o.op = OP_SQRT_STEP;
      ST_CORDIC_INIT: cmd_o.op = OP_CORDIC_INIT;
      ST_CORDIC:      cmd_o.op = OP_CORDIC_STEP;
      ST_SPECIAL:     cmd_o.op = OP_SPECIAL;
      ST_DEG_GO:      cmd_o.op = OP_DEG_GO;
      ST_DEG_WAIT:    cmd_o.op = OP_DEG_WAIT;
      ST_RATE_GO:     cmd_o.op = OP_RATE_GO;
      ST_RATE_WAIT:   cmd_o.op = OP_RATE_WAIT;
      ST_GTERM_GO:    cmd_o.op = OP_GTERM_GO;
      ST_GTERM_WAIT:  cmd_o.op = OP_GTERM_WAIT;
      ST_SUM:         cmd_o.op = OP_SUM;
      ST_BLEND_GO:    cmd_o.op = OP_BLEND_GO;
      ST_BLEND_WAIT:  cmd_o.op = OP_BLEND_WAIT;
      ST_NEXT:        cmd_o.op = OP_NEXT_AXIS;
      ST_COMMIT:      if (commit_w) cmd_o.op = OP_COMMIT;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

  // result register valid: set on commit, cleared by a transfer
  assign out_valid_d = commit_w || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // division results only arrive while the controller waits for them
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_DEG_WAIT || state_q == ST_RATE_WAIT ||
                        state_q == ST_GTERM_WAIT || state_q == ST_BLEND_WAIT))
    else $error("division done outside a wait state");

  // a new result appears only from the commit state
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("result valid without commit");

  // a commit returns to idle with the result valid; input is taken only in idle
  a_commit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_w |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("commit did not return to idle with a valid result");

endmodule

[hw/rtl/imu_tilt_complementary_filter.sv]
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
// m_axis    out  angle_x, angle_y, angle_z
//
// One sample at a time. Per axis: squares and square root, CORDIC, and four
// constant divisions (reciprocal multiply on four 16-bit digits, each digit
// in a multiply phase and a subtract phase); an axis whose other two
// readings are both zero skips the CORDIC and the degree division.
// Reset clears the stored angles to zero. A finished result waits in the
// output register; the next sample is accepted meanwhile and only its
// commit waits for the output transfer.
module imu_tilt_complementary_filter
  import itcf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_x, angle_y, angle_z
  output logic [95:0]  m_axis_tdata
);

  cmd_t cmd_w;
  sts_t sts_w;

  itcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd_w),
    .sts_i      (sts_w)
  );

  itcf_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_w),
    .sts_o     (sts_w),
    .in_data_i (s_axis_tdata),
    .out_data_o(m_axis_tdata)
  );

endmodule

[tb/imu_tilt_checker.sv]
// Watches both channels, predicts each angle triple and compares it
module imu_tilt_checker #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  output int           fail_cnt_o,
  output int           pending_o
);

  logic [95:0] angle_q[$];
  logic signed [31:0] prev_x, prev_y, prev_z;

  // atan(2^-i) radians in Q32
  function automatic longint atan_step(input int i);
    longint t[24] = '{64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
                      64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
                      64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152,
                      64'd1048576, 64'd524288, 64'd262144, 64'd131072,
                      64'd65536, 64'd32768, 64'd16384, 64'd8192,
                      64'd4096, 64'd2048, 64'd1024, 64'd512};
    return t[i];
  endfunction

  // Integer square root, bit by bit
  function automatic longint isqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Rounded half away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Tilt of axis a from the accelerometer, in degrees
  function automatic longint tilt_deg(input longint a, input longint b, input longint c);
    longint x, y, z, xs, ys;
    x = isqrt(longint'((b * b + c * c) << 16));
    y = a * 256;
    z = 0;
    if (x == 0) begin
      if (a > 0) return longint'(90) <<< ANGLE_FRAC_BITS;
      if (a < 0) return -(longint'(90) <<< ANGLE_FRAC_BITS);
      return 0;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return round_div(z * 9000, longint'(157) <<< (32 - ANGLE_FRAC_BITS));
  endfunction

  // Gyro integration and blend with saturation
  function automatic logic signed [31:0] blend_axis(input logic signed [31:0] prev,
      input longint gyro, input longint ms, input longint tilt);
    longint rate, gterm, v;
    rate = gyro / 131;
    gterm = round_div(rate * ms * (longint'(1) <<< ANGLE_FRAC_BITS), 1000);
    v = round_div(98 * (longint'(prev) + gterm) + 2 * tilt, 100);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  assign pending_o = angle_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint ax, ay, az, ms;
    logic [95:0] exp_v;
    int errs;
    if (!rst_ni) begin
      prev_x <= '0; prev_y <= '0; prev_z <= '0;
      fail_cnt_o <= 0;
    end else begin
      // Input transfer: advance the predicted angles
      if (s_axis_tvalid && s_axis_tready) begin
        ax = longint'($signed(s_axis_tdata[15:0]));
        ay = longint'($signed(s_axis_tdata[31:16]));
        az = longint'($signed(s_axis_tdata[47:32]));
        ms = longint'(s_axis_tdata[111:96]);
        exp_v[31:0]  = blend_axis(prev_x, longint'($signed(s_axis_tdata[63:48])), ms,
                                  tilt_deg(ax, ay, az));
        exp_v[63:32] = blend_axis(prev_y, longint'($signed(s_axis_tdata[79:64])), ms,
                                  tilt_deg(ay, ax, az));
        exp_v[95:64] = blend_axis(prev_z, longint'($signed(s_axis_tdata[95:80])), ms,
                                  tilt_deg(az, ax, ay));
        prev_x <= exp_v[31:0];
        prev_y <= exp_v[63:32];
        prev_z <= exp_v[95:64];
        angle_q.push_back(exp_v);
      end
      // Output transfer: compare with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        errs = 0;
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errs = 1;
        end else begin
          exp_v = angle_q.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (m_axis_tdata[32*k +: 32] !== exp_v[32*k +: 32]) begin
              $display("%0t: angle %0d expected %0d actual %0d", $time, k,
                       $signed(exp_v[32*k +: 32]), $signed(m_axis_tdata[32*k +: 32]));
              errs++;
            end
          end
        end
        if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
      end
    end
  end

endmodule

[tb/imu_tilt_complementary_filter_tb.sv]
module imu_tilt_complementary_filter_tb;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [111:0] s_axis_tdata;  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
  logic         m_axis_tvalid, m_axis_tready;
  logic [95:0]  m_axis_tdata;  // angle_x, angle_y, angle_z
  int           fail_cnt, pending;
  int           stall_cyc;
  bit           quiet_phase, hold_off;

  imu_tilt_complementary_filter uut (.*);

  imu_tilt_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [111:0] random_sample();
    logic [111:0] d;
    for (int f = 0; f < 6; f++) d[16*f +: 16] = pick_raw();
    case ($urandom_range(0, 3))
      0: d[111:96] = 16'($urandom);
      1: d[111:96] = 16'd0;
      default: d[111:96] = 16'($urandom_range(1, 40));
    endcase
    // sometimes zero two accel readings so one radius vanishes
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: begin d[31:16] = '0; d[47:32] = '0; end
        1: begin d[15:0] = '0; d[47:32] = '0; end
        default: begin d[15:0] = '0; d[31:16] = '0; end
      endcase
    end
    return d;
  endfunction

  // valid stays high into the next send when no idle cycle follows
  task automatic send(input logic [111:0] d);
    while (!quiet_phase && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Receiver: random idling, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 33);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cyc <= 0;
    else stall_cyc <= stall_cyc + 1;
    if (stall_cyc > 40000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
    quiet_phase = 0; hold_off = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero radius on every axis, zero interval
    send('0);
    for (int k = 0; k < 4; k++) send({16'hffff, {6{ext[k]}}});
    send({16'd10, 48'd0, 16'd0, 16'd0, 16'h4000});
    send({16'd10, 48'd0, 16'd0, 16'h8000, 16'd0});
    send({16'd10, 48'd0, 16'h7fff, 16'd0, 16'd0});
    send({16'd0, {3{16'h7fff}}, 48'h0001_0001_0001});
    for (int k = 0; k < 8; k++)
      send({16'hffff, {3{16'h7fff}}, 16'h1234, 16'h8000, 16'h4321});
    for (int k = 0; k < 8; k++)
      send({16'hffff, {3{16'h8000}}, 16'h0100, 16'h0200, 16'h8000});

    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (int k = 0; k < 4; k++) send(random_sample());
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    join

    // Random part, with a stretch of no idling
    for (int n = 0; n < 420; n++) begin
      quiet_phase = (n >= 150 && n < 230);
      send(random_sample());
    end
    quiet_phase = 0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
